// ----- sv/dbfa_pkg.sv -----
// Shared constants for the dual bitmap first-fit allocator.
package dbfa_pkg;

  localparam int NUM_W   = 33;
  localparam int LIMIT_W = 16;
  localparam int START_W = 32;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int RESERVED_INODES = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC_INODE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE_INODE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC_DATA  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FREE_DATA   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INODE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 2'd2;

endpackage

// ----- sv/dbfa_ram.sv -----
// Generic simple dual-port RAM with registered read.
module dbfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/dbfa_divw.sv -----
// Two-stage divider by a constant word size: reciprocal multiply, then remainder.
module dbfa_divw #(
  parameter int X_W = 15,
  parameter int DIV = 32,
  parameter int Q_W = 10
) (
  input  logic                     clk,
  input  logic [X_W-1:0]           x,
  output logic [Q_W-1:0]           q,
  output logic [$clog2(DIV)-1:0]   r
);

  localparam int S  = X_W + $clog2(DIV);
  localparam int RW = X_W + 1;
  localparam int PW = X_W + RW;
  localparam longint RECIP_L = ((longint'(1) << S) + longint'(DIV) - 1) / longint'(DIV);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic [PW-1:0]  prod;
  logic [X_W-1:0] x_d;
  logic [X_W-1:0] quo;
  logic [X_W-1:0] rem;

  // Exact for every x below 2**X_W since 2**S >= 2**X_W * DIV.
  assign quo = X_W'(prod >> S);
  assign rem = x_d - X_W'(quo * DIV);

  always_ff @(posedge clk) begin
    prod <= PW'(x) * PW'(RECIP);
    x_d  <= x;
    q    <= Q_W'(quo);
    r    <= rem[$clog2(DIV)-1:0];
  end

endmodule

// ----- sv/dual_bitmap_first_fit_allocator.sv -----
// Dual bitmap first-fit allocator: inode and data block bitmaps in two RAMs.
//
// Requests enter on start/kind/number and are taken when start is high and
// busy is low. Each request gives exactly one result, shown on result_number
// and failed for one cycle with done high; the receiver cannot stall it.
// Configuration writes (cfg_valid/cfg_index/cfg_data) are always ready and
// are meant to be issued while the block is idle.
//
// Allocation streams one bitmap word per cycle out of the RAM of the chosen
// map, so its length is set by the single read port: a hit ends the search
// in the word that holds it, and a full miss reads every word in range.
// An empty search range answers on the next cycle. A free runs the bit
// number through a two-stage constant divider to get the word address and
// bit, then reads (S_FRD), clears the bit and writes back (S_FWR); done
// follows the write-back.
// One request is in flight at a time; the next may be taken in the cycle in
// which done is shown.
// After reset both RAMs are swept to zero, one word a cycle, with busy high;
// the control and configuration registers take their reset values.
module dual_bitmap_first_fit_allocator #(
  parameter int MAP_BITS  = 32768,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [dbfa_pkg::KIND_W-1:0]         kind,
  input  logic [dbfa_pkg::NUM_W-1:0]          number,
  output logic                                done,
  output logic [dbfa_pkg::NUM_W-1:0]          result_number,
  output logic                                failed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = $clog2(MAP_BITS);
  localparam int TOP_W     = $clog2(MAP_BITS + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int NUM_W     = dbfa_pkg::NUM_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FDIV1 = 3'd3;
  localparam logic [2:0] S_FDIV2 = 3'd4;
  localparam logic [2:0] S_FRD   = 3'd5;
  localparam logic [2:0] S_FWR   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [dbfa_pkg::LIMIT_W-1:0] inode_limit;
  logic [dbfa_pkg::LIMIT_W-1:0] data_limit;
  logic [dbfa_pkg::START_W-1:0] data_start;

  logic [AW-1:0]    clr_addr;
  logic             use_data;
  logic [AW-1:0]    iss_addr;
  logic [TOP_W-1:0] iss_base;
  logic [TOP_W-1:0] iss_remain;
  logic             iss_more;
  logic             iss_first;
  logic [AW-1:0]    chk_addr;
  logic [TOP_W-1:0] chk_base;
  logic [TOP_W-1:0] chk_remain;
  logic             chk_valid;
  logic             chk_first;
  logic             fr_valid;
  logic [IDX_W-1:0] fr_x;

  logic [AW-1:0]          div_q;
  logic [BIT_W-1:0]       div_r;
  logic [WORD_BITS-1:0]   inode_rdata;
  logic [WORD_BITS-1:0]   data_rdata;
  logic [WORD_BITS-1:0]   rdata_sel;
  logic [WORD_BITS-1:0]   set_word;
  logic [WORD_BITS-1:0]   clr_word;
  logic [WORD_BITS-1:0]   wdata;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic                   inode_we;
  logic                   data_we;

  logic                   accept;
  logic                   req_alloc;
  logic                   req_data;
  logic [TOP_W-1:0]       req_top;
  logic [TOP_W-1:0]       req_lo;
  logic [31:0]            req_lim;
  logic                   req_empty;
  logic                   free_ok;
  logic [IDX_W-1:0]       free_x;
  logic [NUM_W-1:0]       data_off;

  logic                   found;
  logic [BIT_W-1:0]       found_pos;
  logic [IDX_W-1:0]       found_idx;
  logic                   chk_last;
  logic                   scan_hit;
  logic                   scan_miss;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Request decode at transfer.
  assign req_alloc = (kind == dbfa_pkg::KIND_ALLOC_INODE) ||
                     (kind == dbfa_pkg::KIND_ALLOC_DATA);
  assign req_data  = (kind == dbfa_pkg::KIND_ALLOC_DATA) ||
                     (kind == dbfa_pkg::KIND_FREE_DATA);
  assign req_lim   = req_data ? {16'd0, data_limit} : {16'd0, inode_limit};
  assign req_top   = (req_lim < 32'(MAP_BITS)) ? TOP_W'(req_lim) : TOP_W'(MAP_BITS);
  assign req_lo    = req_data ? '0 : TOP_W'(dbfa_pkg::RESERVED_INODES);
  assign req_empty = (req_top <= req_lo);
  assign data_off  = number - {1'b0, data_start};

  always_comb begin
    if (req_data) begin
      free_ok = (number >= {1'b0, data_start}) && (data_off < NUM_W'(MAP_BITS));
      free_x  = data_off[IDX_W-1:0];
    end else begin
      free_ok = (number >= NUM_W'(dbfa_pkg::RESERVED_INODES)) &&
                (number < NUM_W'(MAP_BITS));
      free_x  = number[IDX_W-1:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inode_limit <= 16'd32768;
      data_limit  <= 16'd32768;
      data_start  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dbfa_pkg::CFG_INODE_LIMIT: inode_limit <= cfg_data[dbfa_pkg::LIMIT_W-1:0];
        dbfa_pkg::CFG_DATA_LIMIT:  data_limit  <= cfg_data[dbfa_pkg::LIMIT_W-1:0];
        dbfa_pkg::CFG_DATA_START:  data_start  <= cfg_data[dbfa_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  assign rdata_sel = use_data ? data_rdata : inode_rdata;

  // Lowest clear bit of the checked word inside the search range.
  always_comb begin
    logic [WORD_BITS-1:0] avail;
    found     = 1'b0;
    found_pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j] = !rdata_sel[j] && (TOP_W'(j) < chk_remain) &&
                 !(chk_first && !use_data && (j < dbfa_pkg::RESERVED_INODES));
    end
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        found     = 1'b1;
        found_pos = BIT_W'(j);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      set_word[j] = rdata_sel[j] || (BIT_W'(j) == found_pos);
      clr_word[j] = rdata_sel[j] && (BIT_W'(j) != div_r);
    end
  end

  assign found_idx = IDX_W'(chk_base + TOP_W'(found_pos));
  assign chk_last  = (chk_remain <= TOP_W'(WORD_BITS));
  assign scan_hit  = (state == S_SCAN) && chk_valid && found;
  assign scan_miss = (state == S_SCAN) && chk_valid && !found && chk_last;

  // RAM port control.
  always_comb begin
    waddr    = chk_addr;
    wdata    = set_word;
    raddr    = iss_addr;
    inode_we = 1'b0;
    data_we  = 1'b0;
    case (state)
      S_CLEAR: begin
        waddr    = clr_addr;
        wdata    = '0;
        inode_we = 1'b1;
        data_we  = 1'b1;
      end
      S_SCAN: begin
        inode_we = scan_hit && !use_data;
        data_we  = scan_hit && use_data;
      end
      S_FRD: begin
        raddr = div_q;
      end
      S_FWR: begin
        waddr    = div_q;
        wdata    = clr_word;
        inode_we = fr_valid && !use_data;
        data_we  = fr_valid && use_data;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_alloc) begin
            state_next = req_empty ? S_IDLE : S_SCAN;
          end else begin
            state_next = S_FDIV1;
          end
        end
      end
      S_CLEAR: begin
        if (clr_addr == AW'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_miss) begin
          state_next = S_IDLE;
        end
      end
      S_FDIV1: state_next = S_FDIV2;
      S_FDIV2: state_next = S_FRD;
      S_FRD:   state_next = S_FWR;
      S_FWR:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      done      <= 1'b0;
      chk_valid <= 1'b0;
      iss_more  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (accept && req_alloc && req_empty) begin
        done <= 1'b1;
      end
      if (scan_hit || scan_miss || state == S_FWR) begin
        done <= 1'b1;
      end
      if (accept) begin
        iss_more  <= req_alloc && !req_empty;
        chk_valid <= 1'b0;
      end else if (state == S_SCAN) begin
        // Advance the read stream one word a cycle; stop after the last word.
        chk_valid <= iss_more;
        if (iss_more && iss_remain <= TOP_W'(WORD_BITS)) begin
          iss_more <= 1'b0;
        end
      end else begin
        chk_valid <= 1'b0;
        iss_more  <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      use_data   <= req_data;
      iss_addr   <= '0;
      iss_base   <= '0;
      iss_remain <= req_top;
      iss_first  <= 1'b1;
      fr_valid   <= free_ok;
      fr_x       <= free_x;
    end else if (state == S_SCAN && iss_more) begin
      chk_addr   <= iss_addr;
      chk_base   <= iss_base;
      chk_remain <= iss_remain;
      chk_first  <= iss_first;
      iss_first  <= 1'b0;
      if (iss_remain > TOP_W'(WORD_BITS)) begin
        iss_addr   <= iss_addr + AW'(1);
        iss_base   <= iss_base + TOP_W'(WORD_BITS);
        iss_remain <= iss_remain - TOP_W'(WORD_BITS);
      end
    end
    if (accept) begin
      result_number <= '0;
      failed        <= req_alloc;
    end else if (scan_hit) begin
      result_number <= use_data ? (NUM_W'(data_start) + NUM_W'(found_idx))
                                : NUM_W'(found_idx);
      failed        <= 1'b0;
    end else if (scan_miss) begin
      result_number <= '0;
      failed        <= 1'b1;
    end else if (state == S_FWR) begin
      result_number <= '0;
      failed        <= 1'b0;
    end
  end

  dbfa_divw #(
    .X_W (IDX_W),
    .DIV (WORD_BITS),
    .Q_W (AW)
  ) u_divw (
    .clk (clk),
    .x   (fr_x),
    .q   (div_q),
    .r   (div_r)
  );

  dbfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_inode_ram (
    .clk   (clk),
    .we    (inode_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (inode_rdata)
  );

  dbfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (data_rdata)
  );

  a_accept_then_work: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("transfer neither started work nor produced a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a request is still in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && failed) |-> (result_number == '0))
    else $error("failed allocation carries a nonzero number");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    (inode_we || data_we) |-> (state == S_CLEAR || state == S_SCAN || state == S_FWR))
    else $error("bitmap write outside clear, scan or free write-back");

  a_single_map: assert property (@(posedge clk) disable iff (rst)
    (inode_we && data_we) |-> (state == S_CLEAR))
    else $error("both bitmaps written outside the clearing sweep");

endmodule
